// File: sv/cpu_effective_address_unit_defines.svh
// Assertion macros shared by the effective address unit.
// Each expects signals named clk and rst in the module that uses it.
`ifndef CPU_EFFECTIVE_ADDRESS_UNIT_DEFINES_SVH
`define CPU_EFFECTIVE_ADDRESS_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CEAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define CEAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ceau_pkg.sv
package ceau_pkg;

  // Addressing mode codes
  localparam logic [3:0] MODE_IMP = 4'd0;
  localparam logic [3:0] MODE_ACC = 4'd1;
  localparam logic [3:0] MODE_IMM = 4'd2;
  localparam logic [3:0] MODE_ZP  = 4'd3;
  localparam logic [3:0] MODE_ZPX = 4'd4;
  localparam logic [3:0] MODE_ZPY = 4'd5;
  localparam logic [3:0] MODE_ABS = 4'd6;
  localparam logic [3:0] MODE_ABX = 4'd7;
  localparam logic [3:0] MODE_ABY = 4'd8;
  localparam logic [3:0] MODE_IND = 4'd9;
  localparam logic [3:0] MODE_IZX = 4'd10;
  localparam logic [3:0] MODE_IZY = 4'd11;
  localparam logic [3:0] MODE_REL = 4'd12;

  // Result kinds
  localparam logic RK_REQUEST = 1'b0;
  localparam logic RK_DONE    = 1'b1;

  localparam logic [15:0] PAGE_MASK = 16'hFF00;
  localparam logic [7:0]  SIGN_BIT  = 8'h80;
  localparam logic [15:0] ZP_MASK   = 16'h00FF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        data_valid;
    logic [3:0]  mode;
    logic [15:0] pc_in;
    logic [7:0]  x_index;
    logic [7:0]  y_index;
    logic [7:0]  read_data;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] read_address;
    logic [15:0] effective_address;
    logic [15:0] relative_offset;
    logic [15:0] next_pc;
    logic        page_crossed;
    logic        operand_is_accumulator;
  } out_item_t;

  // How a start command behaves
  typedef enum logic [1:0] {
    SK_FETCH,
    SK_ACC,
    SK_IMM,
    SK_IMP
  } start_kind_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic        is_start;
    start_kind_t kind;
    logic [3:0]  mode;
    logic [15:0] pc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  data;
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_OP_LO  = 5'b00010,
    PH_OP_HI  = 5'b00100,
    PH_PTR_LO = 5'b01000,
    PH_PTR_HI = 5'b10000
  } phase_t;

endpackage

// File: sv/ceau_front.sv
module ceau_front import ceau_pkg::*; (
  input  in_item_t item,
  output cmd_t     cmd
);

  start_kind_t kind;

  // Classify the mode of a start command; unused codes behave as implied.
  always_comb begin
    priority if (item.mode == MODE_ACC) begin
      kind = SK_ACC;
    end else if (item.mode == MODE_IMM) begin
      kind = SK_IMM;
    end else if (item.mode == MODE_IMP || item.mode > MODE_REL) begin
      kind = SK_IMP;
    end else begin
      kind = SK_FETCH;
    end
  end

  assign cmd.is_start = ~item.data_valid;
  assign cmd.kind     = kind;
  assign cmd.mode     = item.mode;
  assign cmd.pc       = item.pc_in;
  assign cmd.x        = item.x_index;
  assign cmd.y        = item.y_index;
  assign cmd.data     = item.read_data;

endmodule

// File: sv/ceau_queue.sv
module ceau_queue import ceau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_data
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  function automatic logic [QPTR_W-1:0] advance(input logic [QPTR_W-1:0] p);
    advance = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= advance(wr_ptr);
      if (do_pop) rd_ptr <= advance(rd_ptr);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// File: sv/ceau_back.sv
`include "cpu_effective_address_unit_defines.svh"

module ceau_back import ceau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_pop,
  input  cmd_t      q_data,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp
);

  phase_t      phase, phase_next;
  logic [3:0]  mode, mode_next;
  logic [15:0] work_pc, work_pc_next;
  logic [7:0]  idx_x, idx_x_next;
  logic [7:0]  idx_y, idx_y_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [7:0]  high_byte, high_byte_next;
  logic [15:0] pointer, pointer_next;
  logic        emit;
  out_item_t   res;

  logic [15:0] pc_inc;
  logic [15:0] base;
  logic [7:0]  idx_sel;
  logic [15:0] indexed;
  logic [15:0] rel;
  logic [7:0]  d;

  // Take a command whenever the output slot is free or draining.
  assign q_pop = q_valid & (~rsp_valid | rsp_ready);
  assign d     = q_data.data;

  assign pc_inc  = work_pc + 16'd1;
  assign rel     = (d & SIGN_BIT) != 8'd0 ? ({8'd0, d} | PAGE_MASK) : {8'd0, d};
  // Base for indexed and absolute finishes and the indirect pointer: high byte arrives now, low byte is stored.
  assign base    = {d, low_byte};
  assign idx_sel = (mode == MODE_ABX) ? idx_x : idx_y;
  assign indexed = base + {8'd0, idx_sel};

  always_comb begin
    phase_next     = phase;
    mode_next      = mode;
    work_pc_next   = work_pc;
    idx_x_next     = idx_x;
    idx_y_next     = idx_y;
    low_byte_next  = low_byte;
    high_byte_next = high_byte;
    pointer_next   = pointer;
    emit           = 1'b1;
    res            = '0;
    res.result_kind = RK_REQUEST;

    if (q_data.is_start) begin
      mode_next    = q_data.mode;
      work_pc_next = q_data.pc;
      idx_x_next   = q_data.x;
      idx_y_next   = q_data.y;
      phase_next   = PH_IDLE;
      res.result_kind = RK_DONE;
      res.next_pc     = q_data.pc;
      unique case (q_data.kind)
        SK_ACC: res.operand_is_accumulator = 1'b1;
        SK_IMM: begin
          res.effective_address = q_data.pc;
          res.next_pc           = q_data.pc + 16'd1;
        end
        SK_IMP: res.effective_address = '0;
        SK_FETCH: begin
          res             = '0;
          res.result_kind = RK_REQUEST;
          res.read_address = q_data.pc;
          phase_next      = PH_OP_LO;
        end
        default: ;
      endcase
    end else begin
      unique case (phase)
        PH_OP_LO: begin
          low_byte_next   = d;
          work_pc_next    = pc_inc;
          res.result_kind = RK_DONE;
          res.next_pc     = pc_inc;
          phase_next      = PH_IDLE;
          if (mode == MODE_ZP) begin
            res.effective_address = {8'd0, d};
          end else if (mode == MODE_ZPX) begin
            res.effective_address = ZP_MASK & {8'd0, d + idx_x};
          end else if (mode == MODE_ZPY) begin
            res.effective_address = ZP_MASK & {8'd0, d + idx_y};
          end else if (mode == MODE_REL) begin
            res.effective_address = pc_inc + rel;
            res.relative_offset   = rel;
          end else if (mode == MODE_IZX || mode == MODE_IZY) begin
            pointer_next     = (mode == MODE_IZX) ? {8'd0, d + idx_x} : {8'd0, d};
            res              = '0;
            res.result_kind  = RK_REQUEST;
            res.read_address = pointer_next;
            phase_next       = PH_PTR_LO;
          end else begin
            res              = '0;
            res.result_kind  = RK_REQUEST;
            res.read_address = pc_inc;
            phase_next       = PH_OP_HI;
          end
        end
        PH_OP_HI: begin
          high_byte_next  = d;
          work_pc_next    = pc_inc;
          res.result_kind = RK_DONE;
          res.next_pc     = pc_inc;
          phase_next      = PH_IDLE;
          if (mode == MODE_ABX || mode == MODE_ABY) begin
            res.effective_address = indexed;
            res.page_crossed      = (indexed & PAGE_MASK) != (base & PAGE_MASK);
          end else if (mode == MODE_IND) begin
            pointer_next     = base;
            res              = '0;
            res.result_kind  = RK_REQUEST;
            res.read_address = base;
            phase_next       = PH_PTR_LO;
          end else begin
            res.effective_address = base;
          end
        end
        PH_PTR_LO: begin
          // Pointer high byte stays within the page of the pointer.
          low_byte_next    = d;
          res.read_address = (pointer & PAGE_MASK) | (ZP_MASK & (pointer + 16'd1));
          phase_next       = PH_PTR_HI;
        end
        PH_PTR_HI: begin
          high_byte_next  = d;
          res.result_kind = RK_DONE;
          res.next_pc     = work_pc;
          phase_next      = PH_IDLE;
          if (mode == MODE_IZY) begin
            res.effective_address = indexed;
            res.page_crossed      = (indexed & PAGE_MASK) != (base & PAGE_MASK);
          end else begin
            res.effective_address = base;
          end
        end
        default: begin
          // Data with no request pending: drop it.
          emit       = 1'b0;
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        phase     <= phase_next;
        rsp_valid <= emit;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mode      <= mode_next;
      work_pc   <= work_pc_next;
      idx_x     <= idx_x_next;
      idx_y     <= idx_y_next;
      low_byte  <= low_byte_next;
      high_byte <= high_byte_next;
      pointer   <= pointer_next;
      if (emit) rsp <= res;
    end
  end

  `CEAU_ASSERT_NXT(a_instant_start_idle, q_pop && q_data.is_start && q_data.kind != SK_FETCH, phase == PH_IDLE, "instant start left a read pending")
  `CEAU_ASSERT_IMP(a_done_no_address, rsp_valid && rsp.result_kind == RK_DONE, rsp.read_address == 16'd0, "finished result carries a read address")
  `CEAU_ASSERT_IMP(a_ptr_modes, phase == PH_PTR_LO || phase == PH_PTR_HI, mode == MODE_IND || mode == MODE_IZX || mode == MODE_IZY, "pointer phase in a mode without a pointer")

endmodule

// File: sv/cpu_effective_address_unit.sv
// Effective address unit for the 6502 addressing modes.
// A result reaches rsp through the queue and then the back end's output register.
// One command per cycle unless rsp stalls; the back end steps once per queued command.
// Reset (rst, synchronous): queue emptied, phase idle, no response pending.
// Commands with data_valid high and nothing pending are dropped with no response.
module cpu_effective_address_unit import ceau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  in_item_t  cmd,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp
);

  // Front end: classify each command by mode with no state of its own, so
  // it never waits on the back end except when the queue is full.
  cmd_t classified;

  ceau_front u_front (
    .item (cmd),
    .cmd  (classified)
  );

  // Short queue between front and back; each side stalls on its own.
  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  ceau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  (classified),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // Back end: phase machine that issues read requests, gathers operand and
  // pointer bytes and forms the final address. Its output register accepts a
  // new result in the same cycle the previous one transfers.
  ceau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: tb/sv/cpu_effective_address_unit_tb.sv
module cpu_effective_address_unit_tb;
  import ceau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Values of the data_valid field of a command.
  localparam logic DV_START = 1'b0;
  localparam logic DV_DATA  = 1'b1;

  // Highest mode code the field can carry; codes above MODE_REL are unused.
  localparam logic [3:0] MODE_UNUSED_TOP = 4'd15;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // Tracks the address calculation in flight and owes one response per
  // command that the unit does not drop.
  class address_calc_tracker;
    phase_t      step;
    logic [3:0]  cur_mode;
    logic [15:0] pc_now;
    logic [7:0]  xr;
    logic [7:0]  yr;
    logic [7:0]  byte_lo;
    logic [7:0]  byte_hi;
    logic [15:0] ptr_addr;
    out_item_t   owed[$];
    int          mismatches;

    function new();
      step       = PH_IDLE;
      cur_mode   = MODE_IMP;
      pc_now     = '0;
      xr         = '0;
      yr         = '0;
      byte_lo    = '0;
      byte_hi    = '0;
      ptr_addr   = '0;
      mismatches = 0;
    endfunction

    function bit awaiting_read();
      return step != PH_IDLE;
    endfunction

    function out_item_t read_request(logic [15:0] addr);
      out_item_t r;
      r = '0;
      r.result_kind  = RK_REQUEST;
      r.read_address = addr;
      return r;
    endfunction

    function out_item_t finished(logic [15:0] ea, logic [15:0] offset, logic [15:0] npc,
                                 logic crossed, logic acc);
      out_item_t r;
      r = '0;
      r.result_kind            = RK_DONE;
      r.effective_address      = ea;
      r.relative_offset        = offset;
      r.next_pc                = npc;
      r.page_crossed           = crossed;
      r.operand_is_accumulator = acc;
      step = PH_IDLE;
      return r;
    endfunction

    function out_item_t indexed_done(logic [7:0] idx);
      logic [15:0] base;
      logic [15:0] ea;
      base = {byte_hi, byte_lo};
      ea   = base + {8'h00, idx};
      return finished(ea, '0, pc_now, (ea & PAGE_MASK) != (base & PAGE_MASK), 1'b0);
    endfunction

    // Advance the calculation by one accepted command; return 1 when it owes a response.
    function bit take_command(in_item_t c);
      out_item_t   r;
      logic [15:0] offset;
      if (c.data_valid == DV_START) begin
        cur_mode = c.mode;
        pc_now   = c.pc_in;
        xr       = c.x_index;
        yr       = c.y_index;
        if (cur_mode == MODE_ACC)
          r = finished('0, '0, pc_now, 1'b0, 1'b1);
        else if (cur_mode == MODE_IMM)
          r = finished(pc_now, '0, pc_now + 16'd1, 1'b0, 1'b0);
        else if (cur_mode == MODE_IMP || cur_mode > MODE_REL)
          r = finished('0, '0, pc_now, 1'b0, 1'b0);
        else begin
          step = PH_OP_LO;
          r = read_request(pc_now);
        end
      end else begin
        case (step)
          PH_OP_LO: begin
            byte_lo = c.read_data;
            pc_now  = pc_now + 16'd1;
            case (cur_mode)
              MODE_ZP:  r = finished({8'h00, byte_lo}, '0, pc_now, 1'b0, 1'b0);
              MODE_ZPX: r = finished(({8'h00, byte_lo} + xr) & ZP_MASK, '0, pc_now, 1'b0, 1'b0);
              MODE_ZPY: r = finished(({8'h00, byte_lo} + yr) & ZP_MASK, '0, pc_now, 1'b0, 1'b0);
              MODE_REL: begin
                offset = ((byte_lo & SIGN_BIT) != 0) ? (PAGE_MASK | byte_lo) : {8'h00, byte_lo};
                r = finished(pc_now + offset, offset, pc_now, 1'b0, 1'b0);
              end
              MODE_IZX: begin
                ptr_addr = ({8'h00, byte_lo} + xr) & ZP_MASK;
                step = PH_PTR_LO;
                r = read_request(ptr_addr);
              end
              MODE_IZY: begin
                ptr_addr = {8'h00, byte_lo};
                step = PH_PTR_LO;
                r = read_request(ptr_addr);
              end
              default: begin
                step = PH_OP_HI;
                r = read_request(pc_now);
              end
            endcase
          end
          PH_OP_HI: begin
            byte_hi = c.read_data;
            pc_now  = pc_now + 16'd1;
            if (cur_mode == MODE_ABX)
              r = indexed_done(xr);
            else if (cur_mode == MODE_ABY)
              r = indexed_done(yr);
            else if (cur_mode == MODE_IND) begin
              ptr_addr = {byte_hi, byte_lo};
              step = PH_PTR_LO;
              r = read_request(ptr_addr);
            end else
              r = finished({byte_hi, byte_lo}, '0, pc_now, 1'b0, 1'b0);
          end
          PH_PTR_LO: begin
            byte_lo = c.read_data;
            step = PH_PTR_HI;
            r = read_request((ptr_addr & PAGE_MASK) | ((ptr_addr + 16'd1) & ZP_MASK));
          end
          PH_PTR_HI: begin
            byte_hi = c.read_data;
            if (cur_mode == MODE_IZY)
              r = indexed_done(yr);
            else
              r = finished({byte_hi, byte_lo}, '0, pc_now, 1'b0, 1'b0);
          end
          default: return 1'b0;
        endcase
      end
      owed.push_back(r);
      return 1'b1;
    endfunction

    function string describe(out_item_t r);
      return $sformatf("kind %0d raddr %h ea %h rel %h npc %h cross %0d acc %0d",
                       r.result_kind, r.read_address, r.effective_address,
                       r.relative_offset, r.next_pc, r.page_crossed,
                       r.operand_is_accumulator);
    endfunction

    function void match_response(out_item_t got);
      out_item_t want;
      bit        bad;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("response with nothing outstanding: %s", describe(got));
        return;
      end
      want = owed.pop_front();
      bad = (got.result_kind !== want.result_kind) ||
            (got.read_address !== want.read_address) ||
            (got.effective_address !== want.effective_address) ||
            (got.relative_offset !== want.relative_offset) ||
            (got.next_pc !== want.next_pc) ||
            (got.page_crossed !== want.page_crossed) ||
            (got.operand_is_accumulator !== want.operand_is_accumulator);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("response mismatch at %0t", $realtime);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_ready;
  in_item_t  cmd;
  logic      rsp_valid;
  logic      rsp_ready;
  out_item_t rsp;

  address_calc_tracker tracker = new();

  int send_gap_pct;   // chance in 100, drawn anew each time, that the sender holds off
  int stall_pct;      // chance in 100, drawn at each edge, that the receiver stalls
  int counted_cmds;   // transfers that the unit answers
  int cycle_count;

  cpu_effective_address_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Receiver: stall at random; values seen just after the edge are the
  // ones the unit presented at that edge.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every response transfer against the oldest owed response.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready)
      tracker.match_response(rsp);
  end

  // Watchdog: end a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Present one command and hold it until the transfer. Lower valid only
  // for a hold-off, so valid is never lowered and raised in one step.
  task automatic transfer_cmd(input in_item_t item);
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= item;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    if (tracker.take_command(item))
      counted_cmds++;
  endtask

  // Start a calculation; fill the unused read_data field with noise.
  task automatic start_cmd(input logic [3:0] m, input logic [15:0] pc,
                           input logic [7:0] x, input logic [7:0] y);
    in_item_t c;
    c.data_valid = DV_START;
    c.mode       = m;
    c.pc_in      = pc;
    c.x_index    = x;
    c.y_index    = y;
    c.read_data  = 8'($urandom);
    transfer_cmd(c);
  endtask

  // Return a read byte; the start-only fields carry noise.
  task automatic data_cmd(input logic [7:0] d);
    in_item_t c;
    c.data_valid = DV_DATA;
    c.mode       = 4'($urandom);
    c.pc_in      = 16'($urandom);
    c.x_index    = 8'($urandom);
    c.y_index    = 8'($urandom);
    c.read_data  = d;
    transfer_cmd(c);
  endtask

  // Mostly complete calculations with random content; some are cut short
  // by a new start, some reads arrive with nothing outstanding.
  task automatic run_random(input int goal);
    int          pick;
    int          cut;
    logic [3:0]  m;
    logic [15:0] pc;
    while (counted_cmds < goal) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0)
        m = 4'($urandom_range(MODE_UNUSED_TOP));
      else
        m = 4'($urandom_range(MODE_REL));
      if ($urandom_range(7) == 0)
        pc = 16'hFFFF - 16'($urandom_range(3));
      else
        pc = 16'($urandom);
      if (pick < 8) begin
        data_cmd(8'($urandom));
      end else begin
        start_cmd(m, pc, 8'($urandom), 8'($urandom));
        if (pick < 20) begin
          // Drop the calculation partway: the next start abandons it.
          cut = $urandom_range(3);
          while (tracker.awaiting_read() && cut > 0) begin
            data_cmd(8'($urandom));
            cut--;
          end
        end else begin
          while (tracker.awaiting_read()) data_cmd(8'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd          = '0;
    send_gap_pct = 7;
    stall_pct    = 80;
    counted_cmds = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every mode, the field extremes and the odd cases.
    start_cmd(MODE_IMP, 16'h0000, 8'h00, 8'h00);
    start_cmd(MODE_ACC, 16'hFFFF, 8'hFF, 8'hFF);
    start_cmd(MODE_IMM, 16'hFFFF, 8'h00, 8'h00);   // next pc wraps to zero
    data_cmd(8'h5A);                               // read byte with nothing pending: dropped
    start_cmd(MODE_UNUSED_TOP, 16'h8000, 8'h55, 8'hAA);  // unused code acts as implied
    start_cmd(MODE_ZPX, 16'hFFFF, 8'hFF, 8'h00);
    data_cmd(8'hFF);                               // zero-page index wraps
    start_cmd(MODE_ZPY, 16'h1234, 8'h00, 8'h01);
    data_cmd(8'hFF);
    start_cmd(MODE_ABX, 16'h2000, 8'hFF, 8'h00);
    data_cmd(8'h01);
    data_cmd(8'h12);                               // index crosses into the next page
    start_cmd(MODE_ABY, 16'hFFFE, 8'h00, 8'h01);
    data_cmd(8'hFF);
    data_cmd(8'hFF);                               // address wraps past the top
    start_cmd(MODE_IND, 16'h0300, 8'h00, 8'h00);
    data_cmd(8'hFF);
    data_cmd(8'h10);                               // pointer high byte stays in its page
    data_cmd(8'h34);
    data_cmd(8'h12);
    start_cmd(MODE_IZX, 16'h0400, 8'h01, 8'h00);
    data_cmd(8'hFE);                               // pointer at the top of page zero
    data_cmd(8'hAA);
    data_cmd(8'h55);
    start_cmd(MODE_IZY, 16'h0500, 8'h00, 8'hFF);
    data_cmd(8'hFF);
    data_cmd(8'hFF);
    data_cmd(8'h80);
    start_cmd(MODE_REL, 16'h0000, 8'h00, 8'h00);
    data_cmd(8'h80);                               // backward branch below zero
    start_cmd(MODE_ABS, 16'h0600, 8'h00, 8'h00);
    data_cmd(8'h34);
    start_cmd(MODE_ZP, 16'h0700, 8'h00, 8'h00);    // start while busy abandons the fetch
    data_cmd(8'h00);

    // Random: sender mostly eager, receiver mostly stalled.
    run_random(counted_cmds + 600);

    // Swap the pressure.
    send_gap_pct = 80;
    stall_pct   <= 7;
    run_random(counted_cmds + 600);

    // Full rate both ways.
    send_gap_pct = 0;
    stall_pct   <= 0;
    run_random(counted_cmds + 600);

    // Drain: wait for every owed response, then watch for strays.
    cmd_valid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.owed.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
